FILE: hdl/i2c_register_master_assert.svh
// ---------------------------------------------------------------------------
// i2c register master assertion macros
// shared concurrent checks, clocked on clk and disabled while rst_n is low
// ---------------------------------------------------------------------------
`ifndef I2C_REGISTER_MASTER_ASSERT_SVH
`define I2C_REGISTER_MASTER_ASSERT_SVH

// same-cycle implication
`define I2CRM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("i2c register master check failed");

// next-cycle implication
`define I2CRM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("i2c register master check failed");

`endif

FILE: hdl/i2crm_pkg.sv
// ---------------------------------------------------------------------------
// i2crm_pkg
// types, codes and sizes shared by the i2c register master modules
// ---------------------------------------------------------------------------
`default_nettype none

package i2crm_pkg;

  // stream widths
  localparam int IN_TDATA_W  = 32;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 32;

  // command queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // function codes on the input tuser
  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_WRITE = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;

  // completion status codes
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_BUS_BUSY  = 2'd1;
  localparam logic [1:0] STATUS_ADDR_NACK = 2'd2;
  localparam logic [1:0] STATUS_DATA_NACK = 2'd3;

  // direction bit appended to the device address
  localparam logic RW_WRITE = 1'b0;
  localparam logic RW_READ  = 1'b1;

  // number of bits in one bus byte
  localparam logic [3:0] BITS_PER_BYTE = 4'd8;

  // classified command kind
  typedef enum logic [1:0] {
    KIND_TICK     = 2'd0,
    KIND_BEGIN_WR = 2'd1,
    KIND_BEGIN_RD = 2'd2
  } kind_t;

  // bus sequencer steps, one-hot
  typedef enum logic [13:0] {
    STEP_IDLE    = 14'b00000000000001,
    STEP_START   = 14'b00000000000010,
    STEP_RSTART  = 14'b00000000000100,
    STEP_TX_AW   = 14'b00000000001000,
    STEP_ACK_AW  = 14'b00000000010000,
    STEP_TX_REG  = 14'b00000000100000,
    STEP_ACK_REG = 14'b00000001000000,
    STEP_TX_DAT  = 14'b00000010000000,
    STEP_ACK_DAT = 14'b00000100000000,
    STEP_TX_AR   = 14'b00001000000000,
    STEP_ACK_AR  = 14'b00010000000000,
    STEP_RX      = 14'b00100000000000,
    STEP_MACK    = 14'b01000000000000,
    STEP_STOP    = 14'b10000000000000
  } step_t;

  // one queued tick
  typedef struct packed {
    kind_t      kind;
    logic [6:0] dev_addr;
    logic [7:0] reg_addr;
    logic [7:0] byte_count;
    logic [7:0] wr_byte;
    logic       sda_in;
  } entry_t;

  // one result word
  typedef struct packed {
    logic        scl_out;
    logic        sda_out;
    logic [7:0]  rd_byte;
    logic        rd_valid;
    logic        rd_last;
    logic        wr_taken;
    logic        busy_res;
    logic        done_res;
    logic [1:0]  status;
    logic [15:0] error_count;
  } result_t;

endpackage

`default_nettype wire

FILE: hdl/i2crm_front.sv
// ---------------------------------------------------------------------------
// i2crm_front
// unpacks input words and classifies the function code into a command kind
// ---------------------------------------------------------------------------
`default_nettype none

module i2crm_front (
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [i2crm_pkg::IN_TDATA_W-1:0] in_tdata,
  input  wire logic [i2crm_pkg::IN_TUSER_W-1:0] in_tuser,
  output logic                                 push_valid,
  input  wire logic                            push_ready,
  output i2crm_pkg::entry_t                    push_data
);
  import i2crm_pkg::*;

  kind_t kind;

  // begin codes become their kinds, anything else is a plain tick
  always_comb begin
    unique case (in_tuser)
      FUNC_WRITE: kind = KIND_BEGIN_WR;
      FUNC_READ:  kind = KIND_BEGIN_RD;
      default:    kind = KIND_TICK;
    endcase
  end

  // field unpacking from the lowest bit up
  always_comb begin
    push_data.kind       = kind;
    push_data.dev_addr   = in_tdata[6:0];
    push_data.reg_addr   = in_tdata[14:7];
    push_data.byte_count = in_tdata[22:15];
    push_data.wr_byte    = in_tdata[30:23];
    push_data.sda_in     = in_tdata[31];
  end

  assign push_valid = in_tvalid;
  assign in_tready  = push_ready;

endmodule

`default_nettype wire

FILE: hdl/i2crm_queue.sv
// ---------------------------------------------------------------------------
// i2crm_queue
// small first-in first-out queue of classified words between front and back
// ---------------------------------------------------------------------------
`default_nettype none

module i2crm_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push_valid,
  output logic                   push_ready,
  input  wire i2crm_pkg::entry_t push_data,
  output logic                   pop_valid,
  input  wire logic              pop_ready,
  output i2crm_pkg::entry_t      pop_data
);
  import i2crm_pkg::*;

  entry_t                mem_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   wr_ptr_r;
  logic [QUEUE_AW-1:0]   rd_ptr_r;
  logic [QUEUE_AW:0]     count_r;
  logic                  push;
  logic                  pop;

  assign push_ready = (count_r != QUEUE_DEPTH[QUEUE_AW:0]);
  assign pop_valid  = (count_r != '0);
  assign push       = push_valid & push_ready;
  assign pop        = pop_valid & pop_ready;
  assign pop_data   = mem_r[rd_ptr_r];

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: hdl/i2crm_seq.sv
// ---------------------------------------------------------------------------
// i2crm_seq
// bus sequencer: steps the i2c transaction one tick per word, holds a result
// ---------------------------------------------------------------------------
`default_nettype none

`include "i2c_register_master_assert.svh"

module i2crm_seq (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              entry_valid,
  output logic                   entry_ready,
  input  wire i2crm_pkg::entry_t entry,
  output logic                   res_valid,
  input  wire logic              res_ready,
  output i2crm_pkg::result_t     res
);
  import i2crm_pkg::*;

  step_t       step_r,  step_nxt;
  logic [1:0]  phase_r, phase_nxt;
  logic [3:0]  bit_r,   bit_nxt;
  logic [7:0]  left_r,  left_nxt;
  logic [7:0]  shift_r, shift_nxt;
  logic [6:0]  taddr_r, taddr_nxt;
  logic [7:0]  treg_r,  treg_nxt;
  logic        isrd_r,  isrd_nxt;
  logic [15:0] fail_r,  fail_nxt;
  logic        scl_r,   scl_nxt;
  logic        sda_r,   sda_nxt;
  logic [1:0]  stopc_r, stopc_nxt;
  logic        res_valid_r;
  result_t     res_r, res_nxt;
  logic        step_go;
  logic [3:0]  bit_inc;
  logic [7:0]  rx_shift;
  logic [7:0]  left_dec;

  assign entry_ready = !res_valid_r || res_ready;
  assign step_go     = entry_valid && entry_ready;
  assign res_valid   = res_valid_r;
  assign res         = res_r;
  assign bit_inc     = bit_r + 4'd1;
  assign left_dec    = left_r - 8'd1;
  assign rx_shift    = (bit_r != 4'd0) ? {shift_r[6:0], entry.sda_in} : shift_r;

  // next state and result for the tick at the queue head
  always_comb begin
    step_nxt  = step_r;
    phase_nxt = phase_r;
    bit_nxt   = bit_r;
    left_nxt  = left_r;
    shift_nxt = shift_r;
    taddr_nxt = taddr_r;
    treg_nxt  = treg_r;
    isrd_nxt  = isrd_r;
    fail_nxt  = fail_r;
    scl_nxt   = scl_r;
    sda_nxt   = sda_r;
    stopc_nxt = stopc_r;
    res_nxt          = '0;

    unique case (step_r)
      STEP_IDLE: begin
        scl_nxt = 1'b1;
        sda_nxt = 1'b1;
        if (entry.kind == KIND_BEGIN_WR || entry.kind == KIND_BEGIN_RD) begin
          taddr_nxt = entry.dev_addr;
          treg_nxt  = entry.reg_addr;
          left_nxt  = entry.byte_count;
          isrd_nxt  = (entry.kind == KIND_BEGIN_RD);
          step_nxt  = STEP_START;
          phase_nxt = 2'd1;
          bit_nxt   = 4'd0;
        end
      end

      // start condition, sda must be free before and follow the pull after
      STEP_START: begin
        if ((phase_r <= 2'd1 && !entry.sda_in) || (phase_r > 2'd1 && entry.sda_in)) begin
          res_nxt.done_res = 1'b1;
          res_nxt.status   = STATUS_BUS_BUSY;
          fail_nxt         = fail_r + 16'd1;
          step_nxt         = STEP_IDLE;
          phase_nxt        = 2'd0;
          bit_nxt          = 4'd0;
          scl_nxt          = 1'b1;
          sda_nxt          = 1'b1;
        end else if (phase_r <= 2'd1) begin
          scl_nxt   = 1'b1;
          sda_nxt   = 1'b0;
          phase_nxt = 2'd2;
        end else begin
          shift_nxt = {taddr_r, RW_WRITE};
          step_nxt  = STEP_TX_AW;
          phase_nxt = 2'd0;
          bit_nxt   = 4'd0;
        end
      end

      // repeated start, line checks not made
      STEP_RSTART: begin
        if (phase_r == 2'd0) begin
          scl_nxt   = 1'b1;
          sda_nxt   = 1'b1;
          phase_nxt = 2'd1;
        end else if (phase_r == 2'd1) begin
          scl_nxt   = 1'b1;
          sda_nxt   = 1'b0;
          phase_nxt = 2'd2;
        end else begin
          shift_nxt = {taddr_r, RW_READ};
          step_nxt  = STEP_TX_AR;
          phase_nxt = 2'd0;
          bit_nxt   = 4'd0;
        end
      end

      // byte transmit, msb first
      STEP_TX_AW, STEP_TX_REG, STEP_TX_DAT, STEP_TX_AR: begin
        if (phase_r == 2'd0) begin
          scl_nxt   = 1'b0;
          phase_nxt = 2'd1;
        end else if (phase_r == 2'd1) begin
          sda_nxt   = shift_r[7];
          shift_nxt = {shift_r[6:0], 1'b0};
          phase_nxt = 2'd2;
        end else begin
          scl_nxt   = 1'b1;
          bit_nxt   = bit_inc;
          phase_nxt = 2'd0;
          if (bit_inc >= BITS_PER_BYTE) begin
            bit_nxt = 4'd0;
            unique case (step_r)
              STEP_TX_AW:  step_nxt = STEP_ACK_AW;
              STEP_TX_REG: step_nxt = STEP_ACK_REG;
              STEP_TX_DAT: step_nxt = STEP_ACK_DAT;
              default:     step_nxt = STEP_ACK_AR;
            endcase
          end
        end
      end

      // acknowledge slot from the target
      STEP_ACK_AW, STEP_ACK_REG, STEP_ACK_DAT, STEP_ACK_AR: begin
        if (phase_r == 2'd0) begin
          scl_nxt   = 1'b0;
          phase_nxt = 2'd1;
        end else if (phase_r == 2'd1) begin
          sda_nxt   = 1'b1;
          phase_nxt = 2'd2;
        end else if (phase_r == 2'd2) begin
          scl_nxt   = 1'b1;
          phase_nxt = 2'd3;
        end else begin
          scl_nxt   = 1'b0;
          phase_nxt = 2'd0;
          bit_nxt   = 4'd0;
          unique case (step_r)
            STEP_ACK_AW: begin
              if (entry.sda_in) begin
                stopc_nxt = STATUS_ADDR_NACK;
                step_nxt  = STEP_STOP;
              end else begin
                shift_nxt = treg_r;
                step_nxt  = STEP_TX_REG;
              end
            end
            STEP_ACK_REG, STEP_ACK_DAT: begin
              if (step_r == STEP_ACK_REG && isrd_r) begin
                step_nxt = STEP_RSTART;
              end else if (step_r == STEP_ACK_DAT && entry.sda_in) begin
                stopc_nxt = STATUS_DATA_NACK;
                step_nxt  = STEP_STOP;
              end else if (left_r == 8'd0) begin
                stopc_nxt = STATUS_OK;
                step_nxt  = STEP_STOP;
              end else begin
                shift_nxt        = entry.wr_byte;
                step_nxt         = STEP_TX_DAT;
                res_nxt.wr_taken = 1'b1;
                left_nxt         = left_dec;
              end
            end
            default: begin
              if (left_r == 8'd0) begin
                stopc_nxt = STATUS_OK;
                step_nxt  = STEP_STOP;
              end else begin
                shift_nxt = 8'd0;
                step_nxt  = STEP_RX;
              end
            end
          endcase
        end
      end

      // receive, sample on each low phase after the first
      STEP_RX: begin
        if (phase_r == 2'd0) begin
          shift_nxt = rx_shift;
          scl_nxt   = 1'b0;
          if (bit_r >= BITS_PER_BYTE) begin
            res_nxt.rd_byte  = rx_shift;
            res_nxt.rd_valid = 1'b1;
            res_nxt.rd_last  = (left_r == 8'd1);
            step_nxt         = STEP_MACK;
            phase_nxt        = 2'd1;
            bit_nxt          = 4'd0;
          end else begin
            sda_nxt   = 1'b1;
            phase_nxt = 2'd1;
          end
        end else begin
          scl_nxt   = 1'b1;
          bit_nxt   = bit_inc;
          phase_nxt = 2'd0;
        end
      end

      // master ack, nack on the last byte
      STEP_MACK: begin
        if (phase_r <= 2'd1) begin
          sda_nxt   = !(left_r > 8'd1);
          phase_nxt = 2'd2;
        end else if (phase_r == 2'd2) begin
          scl_nxt   = 1'b1;
          phase_nxt = 2'd3;
        end else begin
          scl_nxt   = 1'b0;
          left_nxt  = left_dec;
          phase_nxt = 2'd0;
          bit_nxt   = 4'd0;
          if (left_dec != 8'd0) begin
            shift_nxt = 8'd0;
            step_nxt  = STEP_RX;
          end else begin
            stopc_nxt = STATUS_OK;
            step_nxt  = STEP_STOP;
          end
        end
      end

      // stop condition, then report
      STEP_STOP: begin
        if (phase_r == 2'd0) begin
          scl_nxt   = 1'b0;
          phase_nxt = 2'd1;
        end else if (phase_r == 2'd1) begin
          sda_nxt   = 1'b0;
          phase_nxt = 2'd2;
        end else if (phase_r == 2'd2) begin
          scl_nxt   = 1'b1;
          phase_nxt = 2'd3;
        end else begin
          res_nxt.done_res = 1'b1;
          res_nxt.status   = stopc_r;
          if (stopc_r != STATUS_OK) begin
            fail_nxt = fail_r + 16'd1;
          end
          step_nxt  = STEP_IDLE;
          phase_nxt = 2'd0;
          bit_nxt   = 4'd0;
          scl_nxt   = 1'b1;
          sda_nxt   = 1'b1;
        end
      end

      default: begin
        step_nxt  = STEP_IDLE;
        phase_nxt = 2'd0;
        bit_nxt   = 4'd0;
        scl_nxt   = 1'b1;
        sda_nxt   = 1'b1;
      end
    endcase

    res_nxt.scl_out     = scl_nxt;
    res_nxt.sda_out     = sda_nxt;
    res_nxt.busy_res    = (step_nxt != STEP_IDLE);
    res_nxt.error_count = fail_nxt;
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r  <= STEP_IDLE;
      phase_r <= 2'd0;
      bit_r   <= 4'd0;
      left_r  <= 8'd0;
      shift_r <= 8'd0;
      taddr_r <= 7'd0;
      treg_r  <= 8'd0;
      isrd_r  <= 1'b0;
      fail_r  <= 16'd0;
      scl_r   <= 1'b1;
      sda_r   <= 1'b1;
      stopc_r <= STATUS_OK;
    end else if (step_go) begin
      step_r  <= step_nxt;
      phase_r <= phase_nxt;
      bit_r   <= bit_nxt;
      left_r  <= left_nxt;
      shift_r <= shift_nxt;
      taddr_r <= taddr_nxt;
      treg_r  <= treg_nxt;
      isrd_r  <= isrd_nxt;
      fail_r  <= fail_nxt;
      scl_r   <= scl_nxt;
      sda_r   <= sda_nxt;
      stopc_r <= stopc_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (step_go) begin
      res_valid_r <= 1'b1;
    end else if (res_ready) begin
      res_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_go) begin
      res_r <= res_nxt;
    end
  end

  // checks
  `I2CRM_ASSERT_NOW(a_done_not_busy, res_valid_r && res_r.done_res, !res_r.busy_res)
  `I2CRM_ASSERT_NOW(a_status_needs_done, res_valid_r && res_r.status != STATUS_OK, res_r.done_res)
  `I2CRM_ASSERT_NEXT(a_fail_counts, step_go && res_nxt.status != STATUS_OK, fail_r == $past(fail_r) + 16'd1)
  `I2CRM_ASSERT_NOW(a_idle_released, step_r == STEP_IDLE, scl_r && sda_r)

endmodule

`default_nettype wire

FILE: hdl/i2c_register_master.sv
// ---------------------------------------------------------------------------
// i2c_register_master
// tick-driven i2c master for device register writes and reads
// ---------------------------------------------------------------------------
//  channel | ports                         | payload
//  --------+-------------------------------+--------------------------------
//  input   | in_tvalid in_tready           | tuser func, tdata command/tick
//  result  | out_tvalid out_tready         | tdata line drive/status, tuser
//          |                               | rd_valid, tlast rd_last
//
//  one word per clock cycle while the result side takes results; with an empty queue a word's result
//  is registered first in the queue and then in the sequencer's output register
//  the sequencer step is the only loop: one small state update per word
//  a four-word queue lets the input keep flowing while the result side stalls
//  synchronous active-low reset returns to idle with both lines released
//  no clearing pass after reset
// ---------------------------------------------------------------------------
`default_nettype none

module i2c_register_master (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  // dev_addr[6:0] reg_addr[14:7] byte_count[22:15] wr_byte[30:23] sda_in[31]
  input  wire logic [i2crm_pkg::IN_TDATA_W-1:0]  in_tdata,
  // func[1:0]
  input  wire logic [i2crm_pkg::IN_TUSER_W-1:0]  in_tuser,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // scl_out[0] sda_out[1] rd_byte[9:2] wr_taken[10] busy_res[11]
  // done_res[12] status[14:13] error_count[30:15] zero[31]
  output logic [i2crm_pkg::OUT_TDATA_W-1:0]     out_tdata,
  // rd_valid[0]
  output logic                                  out_tuser,
  output logic                                  out_tlast
);
  import i2crm_pkg::*;

  entry_t  push_data;
  entry_t  pop_data;
  result_t res;
  logic    push_valid;
  logic    push_ready;
  logic    pop_valid;
  logic    pop_ready;

  // front: unpack and classify
  i2crm_front u_front (
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  // queue between front and back
  i2crm_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // back: bus sequencer with output register
  i2crm_seq u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .entry_valid (pop_valid),
    .entry_ready (pop_ready),
    .entry       (pop_data),
    .res_valid   (out_tvalid),
    .res_ready   (out_tready),
    .res         (res)
  );

  // result word packing
  assign out_tdata = {1'b0, res.error_count, res.status, res.done_res, res.busy_res,
                      res.wr_taken, res.rd_byte, res.sda_out, res.scl_out};
  assign out_tuser = res.rd_valid;
  assign out_tlast = res.rd_last;

endmodule

`default_nettype wire
